FILE: design/lgs_pkg.sv
// Package for the life generation step unit: request and response words,
// request codes, controller states and the Conway rule constants.
// No dependencies.
package lgs_pkg;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_ADVANCE = 2'd2;

  localparam int unsigned CMP_W = 7;
  localparam logic [5:0] ACTIVE_SIZE_RESET = 6'd32;

  localparam logic [3:0] SURVIVE_LOW = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] row;
    logic [4:0] col;
    logic       cell_dead;
  } req_word_t;

  typedef struct packed {
    logic       read_dead;
    logic [1:0] done_type;
    logic       bad_address;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_ADV,
    ST_ADV_LAST,
    ST_FINISH
  } ctrl_state_t;

endpackage

FILE: design/life_generation_step_unit.sv
// Top level of the life generation step unit: request decode, controller and
// response register around the grid memory and the row calculator.
// Depends on lgs_pkg, lgs_grid_mem and lgs_row_calc.
//
// The unit holds a square Game of Life grid, one memory word per row, where a
// cell bit of 1 means dead. A cell write or read reads its row from memory on
// acceptance, modifies or samples it in the access state, and then loads the
// response register from the finish state. A read or write with a flagged
// address, and an advance at active size zero, go straight from acceptance to
// the finish state. An advance walks the active square one row per cycle
// through the single memory read port, keeping the two previous old rows in a
// line buffer and writing each new row back once the row below has been read;
// its response word is loaded from the finish state after the last row.
// One request is processed at a time, and the next one is accepted the cycle
// after the response register is loaded; a new request is accepted while the
// previous response still waits in the output register. After reset the grid
// reads as all dead with no clearing pass.
module life_generation_step_unit #(
  parameter int unsigned MAX_SIZE = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [5:0]        cfg_data,
  input  logic              req_valid,
  output logic              req_ready,
  input  lgs_pkg::req_word_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output lgs_pkg::rsp_word_t rsp
);
  import lgs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SIZE);
  localparam int unsigned NW = $clog2(MAX_SIZE + 1);

  ctrl_state_t   state;
  ctrl_state_t   state_next;
  logic [5:0]    active_size;
  logic [NW-1:0] n_eff;
  req_word_t     req_q;
  logic          bad_q;
  logic          bad_in;
  logic          rd_bit;
  logic [AW-1:0] k;
  logic          k_last;
  logic [MAX_SIZE-1:0] prev;
  logic [MAX_SIZE-1:0] cur;
  logic [MAX_SIZE-1:0] calc_below;
  logic [MAX_SIZE-1:0] calc_row;
  logic [MAX_SIZE-1:0] bit_mask;
  logic [MAX_SIZE-1:0] edit_row;
  logic [MAX_SIZE-1:0] shifted_row;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [MAX_SIZE-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [MAX_SIZE-1:0] wr_data;
  logic          load_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= ACTIVE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_size <= cfg_data;
    end
  end

  assign n_eff = (CMP_W'(active_size) > CMP_W'(MAX_SIZE)) ? NW'(MAX_SIZE) : NW'(active_size);
  assign bad_in = (CMP_W'(req.row) >= CMP_W'(n_eff)) || (CMP_W'(req.col) >= CMP_W'(n_eff));
  assign k_last = (CMP_W'(k) + CMP_W'(1)) == CMP_W'(n_eff);

  assign bit_mask    = {{(MAX_SIZE-1){1'b0}}, 1'b1} << req_q.col;
  assign edit_row    = req_q.cell_dead ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
  assign shifted_row = rd_data >> req_q.col;
  assign calc_below  = (state == ST_ADV_LAST) ? '1 : rd_data;

  lgs_grid_mem #(
    .W     (MAX_SIZE),
    .DEPTH (MAX_SIZE),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lgs_row_calc #(
    .W  (MAX_SIZE),
    .NW (NW)
  ) u_calc (
    .above    (prev),
    .mid      (cur),
    .below    (calc_below),
    .n        (n_eff),
    .next_row (calc_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = AW'(req.row);
    wr_en      = 1'b0;
    wr_addr    = AW'(req_q.row);
    wr_data    = edit_row;
    load_rsp   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          priority case (req.req_type)
            REQ_ADVANCE: begin
              if (n_eff != '0) begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_ADV;
              end else begin
                state_next = ST_FINISH;
              end
            end
            REQ_WRITE, REQ_READ: begin
              if (!bad_in) begin
                rd_en      = 1'b1;
                state_next = ST_ACCESS;
              end else begin
                state_next = ST_FINISH;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_ACCESS: begin
        wr_en      = (req_q.req_type == REQ_WRITE);
        state_next = ST_FINISH;
      end
      ST_ADV: begin
        wr_en   = (k != '0);
        wr_addr = k - 1'b1;
        wr_data = calc_row;
        if (k_last) begin
          state_next = ST_ADV_LAST;
        end else begin
          rd_en   = 1'b1;
          rd_addr = k + 1'b1;
        end
      end
      ST_ADV_LAST: begin
        wr_en      = 1'b1;
        wr_addr    = k;
        wr_data    = calc_row;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          load_rsp   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        req_q <= req;
        bad_q <= bad_in && (req.req_type != REQ_ADVANCE);
        k     <= '0;
        prev  <= '1;
      end
      ST_ACCESS: begin
        rd_bit <= shifted_row[0];
      end
      ST_ADV: begin
        cur <= rd_data;
        if (k != '0) begin
          prev <= cur;
        end
        if (!k_last) begin
          k <= k + 1'b1;
        end
      end
      ST_ADV_LAST, ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.read_dead   <= (req_q.req_type == REQ_READ) && !bad_q && rd_bit;
      rsp.done_type   <= req_q.req_type;
      rsp.bad_address <= bad_q;
    end
  end

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_FINISH) |-> !wr_en)
    else $error("grid write outside an access or advance");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_FINISH)
    else $error("response raised outside the finish state");

  a_write_in_square: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> CMP_W'(wr_addr) < CMP_W'(n_eff))
    else $error("grid write outside the active square");

  a_adv_read_ahead: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADV && rd_en) |-> CMP_W'(rd_addr) < CMP_W'(n_eff))
    else $error("advance read beyond the active square");
`endif

endmodule

FILE: design/lgs_grid_mem.sv
// Grid row memory with one registered read port and one write port.
// Rows never written since reset read as all dead through per-row valid bits.
// Depends on nothing but its parameters.
module lgs_grid_mem #(
  parameter int unsigned W     = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] row_valid;
  logic [W-1:0]     mem_q;
  logic             valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = valid_q ? mem_q : '1;

endmodule

FILE: design/lgs_row_calc.sv
// Next-generation logic for one grid row from the old rows above, at and below.
// Cells at or beyond the active size count as dead and keep their old value.
// Depends on lgs_pkg for the rule constants and the compare width.
module lgs_row_calc #(
  parameter int unsigned W  = 32,
  parameter int unsigned NW = 6
) (
  input  logic [W-1:0]  above,
  input  logic [W-1:0]  mid,
  input  logic [W-1:0]  below,
  input  logic [NW-1:0] n,
  output logic [W-1:0]  next_row
);
  import lgs_pkg::*;

  logic [W-1:0] col_in;
  logic [W+1:0] live_a;
  logic [W+1:0] live_m;
  logic [W+1:0] live_b;

  always_comb begin
    for (int c = 0; c < W; c++) begin
      col_in[c] = CMP_W'(c) < CMP_W'(n);
    end
  end

  assign live_a = {1'b0, ~above & col_in, 1'b0};
  assign live_m = {1'b0, ~mid & col_in, 1'b0};
  assign live_b = {1'b0, ~below & col_in, 1'b0};

  always_comb begin
    logic [3:0] cnt;
    logic       alive;
    logic       stays;
    cnt   = '0;
    alive = 1'b0;
    stays = 1'b0;
    for (int c = 0; c < W; c++) begin
      cnt = 4'(live_a[c]) + 4'(live_a[c+1]) + 4'(live_a[c+2])
          + 4'(live_m[c]) + 4'(live_m[c+2])
          + 4'(live_b[c]) + 4'(live_b[c+1]) + 4'(live_b[c+2]);
      alive = live_m[c+1];
      stays = alive ? (cnt == SURVIVE_LOW || cnt == BIRTH_COUNT) : (cnt == BIRTH_COUNT);
      next_row[c] = col_in[c] ? ~stays : mid[c];
    end
  end

endmodule
